// File: sv/assert_macros.svh
// Assertion macros for the top-level RTL file of the LCG draw block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising aclk edge outside of reset.
`define ASSERT_CLKD(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property on every rising aclk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// File: sv/msl_lcg_pkg.sv
// Package: widths, generator constants and controller/datapath interface types.
package msl_lcg_pkg;

    localparam int SEED_W   = 31;
    localparam int PROD_W   = 2 * SEED_W;
    localparam int MULT_W   = 15;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 64;

    localparam logic [MULT_W-1:0] LCG_MULT   = 15'd16807;
    localparam logic [SEED_W-1:0] LCG_MOD    = 31'h7FFF_FFFF;
    localparam logic [SEED_W-1:0] SEED_RESET = 31'd1;

    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;      // capture an accepted request
        logic load_seed;  // write the loaded seed
        logic mul_seed;   // seed times multiplier into the product register
        logic reduce;     // fold the product modulo the prime into the seed
        logic mul_bound;  // seed times upper bound into the product register
        logic emit;       // write the result register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_load;
    } dp_status_t;

endpackage

// File: sv/msl_lcg_dp.sv
// Datapath: seed register, shared multiplier, Mersenne fold and result register.
module msl_lcg_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  msl_lcg_pkg::dp_cmd_t             cmd,
    output msl_lcg_pkg::dp_status_t          status,
    input  logic                             in_command,
    input  logic [msl_lcg_pkg::SEED_W-1:0]   in_new_seed,
    input  logic [msl_lcg_pkg::SEED_W-1:0]   in_upper_bound,
    output logic [msl_lcg_pkg::SEED_W-1:0]   out_state_value,
    output logic [msl_lcg_pkg::SEED_W-1:0]   out_bounded_value,
    output logic                             out_coin
);

    logic [msl_lcg_pkg::SEED_W-1:0] seed_reg, seed_next;
    logic                           command_reg;
    logic [msl_lcg_pkg::SEED_W-1:0] new_seed_reg;
    logic [msl_lcg_pkg::SEED_W-1:0] bound_reg;
    logic [msl_lcg_pkg::PROD_W-1:0] prod_reg;
    logic [msl_lcg_pkg::SEED_W-1:0] state_out_reg;
    logic [msl_lcg_pkg::SEED_W-1:0] bounded_out_reg;
    logic                           coin_out_reg;

    logic [msl_lcg_pkg::SEED_W-1:0] mul_b;
    logic [msl_lcg_pkg::PROD_W-1:0] mul_full;
    logic [msl_lcg_pkg::SEED_W-1:0] prod_hi, prod_lo;
    logic [msl_lcg_pkg::SEED_W:0]   fold_sum, fold_sub;
    logic                           fold_ge;
    logic [msl_lcg_pkg::SEED_W-1:0] fold_rem, quotient, load_value;
    logic                           coin_bit;

    // One multiplier serves both the step and the scaling product.
    assign mul_b = cmd.mul_seed
                 ? {{(msl_lcg_pkg::SEED_W-msl_lcg_pkg::MULT_W){1'b0}}, msl_lcg_pkg::LCG_MULT}
                 : bound_reg;
    assign mul_full = msl_lcg_pkg::PROD_W'(seed_reg) * msl_lcg_pkg::PROD_W'(mul_b);

    // P = hi*2^31 + lo = hi*M + (hi + lo); hi + lo stays below 2M.
    assign prod_hi  = prod_reg[msl_lcg_pkg::PROD_W-1:msl_lcg_pkg::SEED_W];
    assign prod_lo  = prod_reg[msl_lcg_pkg::SEED_W-1:0];
    assign fold_sum = {1'b0, prod_hi} + {1'b0, prod_lo};
    assign fold_ge  = fold_sum >= {1'b0, msl_lcg_pkg::LCG_MOD};
    assign fold_sub = fold_sum - {1'b0, msl_lcg_pkg::LCG_MOD};
    assign fold_rem = fold_ge ? fold_sub[msl_lcg_pkg::SEED_W-1:0]
                              : fold_sum[msl_lcg_pkg::SEED_W-1:0];
    assign quotient = prod_hi + msl_lcg_pkg::SEED_W'(fold_ge);

    // A loaded seed equal to the modulus or zero reduces to zero; force it to one.
    assign load_value = (new_seed_reg == msl_lcg_pkg::LCG_MOD || new_seed_reg == '0)
                      ? msl_lcg_pkg::SEED_RESET : new_seed_reg;

    assign coin_bit = {seed_reg, 1'b0} < {1'b0, msl_lcg_pkg::LCG_MOD};

    always_comb begin
        seed_next = seed_reg;
        if (cmd.load_seed) begin
            seed_next = load_value;
        end else if (cmd.reduce) begin
            seed_next = fold_rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= msl_lcg_pkg::SEED_RESET;
        end else begin
            seed_reg <= seed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            command_reg  <= in_command;
            new_seed_reg <= in_new_seed;
            bound_reg    <= in_upper_bound;
        end
        if (cmd.mul_seed || cmd.mul_bound) begin
            prod_reg <= mul_full;
        end
        if (cmd.emit) begin
            state_out_reg <= seed_reg;
            if (command_reg == msl_lcg_pkg::CMD_LOAD) begin
                bounded_out_reg <= '0;
                coin_out_reg    <= 1'b0;
            end else begin
                bounded_out_reg <= quotient;
                coin_out_reg    <= coin_bit;
            end
        end
    end

    assign status.is_load    = (command_reg == msl_lcg_pkg::CMD_LOAD);
    assign out_state_value   = state_out_reg;
    assign out_bounded_value = bounded_out_reg;
    assign out_coin          = coin_out_reg;

endmodule

// File: sv/msl_lcg_ctrl.sv
// Controller: sequences one request through the datapath and owns the result valid.
module msl_lcg_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    output msl_lcg_pkg::dp_cmd_t      cmd,
    input  msl_lcg_pkg::dp_status_t   status
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_LOAD      = 3'd1;
    localparam logic [2:0] ST_MUL_SEED  = 3'd2;
    localparam logic [2:0] ST_REDUCE    = 3'd3;
    localparam logic [2:0] ST_MUL_BOUND = 3'd4;
    localparam logic [2:0] ST_EMIT      = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    // The result register may be rewritten once its old content is taken.
    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // Decide the path on the latched command.
                if (status.is_load) begin
                    cmd.load_seed = 1'b1;
                    state_next    = ST_EMIT;
                end else begin
                    cmd.mul_seed = 1'b1;
                    state_next   = ST_REDUCE;
                end
            end
            ST_MUL_SEED: begin
                cmd.mul_seed = 1'b1;
                state_next   = ST_REDUCE;
            end
            ST_REDUCE: begin
                cmd.reduce = 1'b1;
                state_next = ST_MUL_BOUND;
            end
            ST_MUL_BOUND: begin
                cmd.mul_bound = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                // Hold until the result register is free.
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: sv/minimal_standard_lcg_draws.sv
// Minimal-standard LCG (multiplier 16807, modulus 2^31-1) with bounded and coin draws.
//
// Input channel s_*: one request per handshake. s_tuser is the command (0 draw,
// 1 load); s_tdata carries the seed to load and the exclusive upper bound.
// Result channel m_*: exactly one result per request, in request order: the
// seed after the request, floor(seed * bound / modulus) and a coin that is 1
// when seed / modulus is below one half (both zero on a load).
// A load passes through the LOAD and EMIT states after acceptance, a draw through
// LOAD, REDUCE, MUL_BOUND and EMIT: the single 31x31 multiplier is used twice
// (seed step, then scaling), each product registered and then split against the
// Mersenne prime. One request is in work at a time; s_tready is high only while
// idle, so a new request is taken only once the last result has been written.
// The result register parts the two sides: a new request is accepted while an
// older result still waits; if m_tready stays low the block holds the finished
// result and stalls before writing the next one.
// Reset (aresetn low, synchronous) sets the seed to 1 and drops m_tvalid.
`include "assert_macros.svh"

module minimal_standard_lcg_draws (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [30:0] new_seed, [61:31] upper_bound, [63:62] zero
    input  logic [msl_lcg_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] command
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [30:0] state_value, [61:31] bounded_value, [62] coin, [63] zero
    output logic [msl_lcg_pkg::M_TDATA_W-1:0]   m_tdata
);

    msl_lcg_pkg::dp_cmd_t    cmd;
    msl_lcg_pkg::dp_status_t status;

    logic [msl_lcg_pkg::SEED_W-1:0] state_value, bounded_value;
    logic                           coin;

    msl_lcg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    msl_lcg_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .in_command        (s_tuser),
        .in_new_seed       (s_tdata[msl_lcg_pkg::SEED_W-1:0]),
        .in_upper_bound    (s_tdata[2*msl_lcg_pkg::SEED_W-1:msl_lcg_pkg::SEED_W]),
        .out_state_value   (state_value),
        .out_bounded_value (bounded_value),
        .out_coin          (coin)
    );

    assign m_tdata = {1'b0, coin, bounded_value, state_value};

    `ASSERT_CLKD(a_seed_in_range, m_tvalid |-> (m_tdata[30:0] != '0 && m_tdata[30:0] != msl_lcg_pkg::LCG_MOD), "seed out of range")
    `ASSERT_CLKD(a_coin_matches_seed, (m_tvalid && m_tdata[62]) |-> !m_tdata[30], "coin set for upper half")
    `ASSERT_CLKD(a_one_in_work, (s_tvalid && s_tready) |=> !s_tready, "second request taken while busy")
    `ASSERT_ALWAYS(a_reset_clears_valid, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

// File: verif/minimal_standard_lcg_draws_test.sv
// Self-checking testbench for the minimal-standard LCG draw block.
`timescale 1ns / 100ps

module minimal_standard_lcg_draws_test;
    import msl_lcg_pkg::*;

    localparam logic [63:0] GEN_MODULUS    = 64'd2147483647;
    localparam logic [63:0] GEN_MULTIPLIER = 64'd16807;
    localparam int DIRECTED_ROWS = 19;
    localparam int RANDOM_ITEMS  = 1480;
    localparam int TOTAL_ITEMS   = DIRECTED_ROWS + RANDOM_ITEMS;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 12;

    typedef struct packed {
        logic [SEED_W-1:0] state;
        logic [SEED_W-1:0] bounded;
        logic              coin;
    } draw_result_t;

    typedef struct packed {
        logic              cmd;
        logic [SEED_W-1:0] seed;
        logic [SEED_W-1:0] bound;
        logic              pinned;   // result below is typed in, not predicted
        draw_result_t      result;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [30:0] new_seed, [61:31] upper_bound, [63:62] zero
    logic                 s_tuser;   // [0] command
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [30:0] state_value, [61:31] bounded_value, [62] coin

    logic                 s_pinned;
    draw_result_t         s_pinned_result;

    logic [SEED_W-1:0]    gen_seed;
    draw_result_t         expected_draws[$];
    int                   errors = 0;
    int                   stall_cycles = 0;
    int                   idle_mode = 0;

    minimal_standard_lcg_draws uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int sender_idle_pct();
        case (idle_mode)
            0:       return 34;
            1:       return 78;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (idle_mode)
            0:       return 78;
            1:       return 34;
            default: return 0;
        endcase
    endfunction

    // Advance the generator copy by one request and return the draw it yields.
    function automatic draw_result_t step_generator(logic cmd, logic [SEED_W-1:0] seed_in,
                                                    logic [SEED_W-1:0] bound);
        logic [63:0]  wide;
        draw_result_t r;
        r = '0;
        if (cmd == CMD_LOAD) begin
            wide = {33'd0, seed_in} % GEN_MODULUS;
            gen_seed = (wide == 64'd0) ? SEED_W'(1) : wide[SEED_W-1:0];
        end else begin
            wide = ({33'd0, gen_seed} * GEN_MULTIPLIER) % GEN_MODULUS;
            gen_seed = wide[SEED_W-1:0];
            wide = ({33'd0, gen_seed} * {33'd0, bound}) / GEN_MODULUS;
            r.bounded = wide[SEED_W-1:0];
            r.coin = ({32'd0, gen_seed, 1'b0} < GEN_MODULUS);
        end
        r.state = gen_seed;
        return r;
    endfunction

    function automatic void check_field(string name, logic [SEED_W-1:0] want,
                                        logic [SEED_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Sample both channels; prediction follows the order in which requests are taken.
    always @(posedge aclk) begin
        draw_result_t want;
        draw_result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want = step_generator(s_tuser, s_tdata[30:0], s_tdata[61:31]);
                if (s_pinned)
                    want = s_pinned_result;
                expected_draws.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.state   = m_tdata[30:0];
                got.bounded = m_tdata[61:31];
                got.coin    = m_tdata[62];
                if (expected_draws.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                             $time, got.state, got.bounded, got.coin);
                    errors++;
                end else begin
                    want = expected_draws.pop_front();
                    check_field("state_value", want.state, got.state);
                    check_field("bounded_value", want.bounded, got.bounded);
                    check_field("coin", SEED_W'(want.coin), SEED_W'(got.coin));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
    end

    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_request(input stim_row_t row);
        while ($urandom_range(0, 99) < sender_idle_pct()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid        <= 1'b1;
        s_tuser         <= row.cmd;
        s_tdata         <= {2'b00, row.bound, row.seed};
        s_pinned        <= row.pinned;
        s_pinned_result <= row.result;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [SEED_W-1:0] random_seed_field();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return 31'h7FFF_FFFF;
            2:       return 31'h7FFF_FFFE;
            3:       return SEED_W'($urandom_range(1, 1000));
            4:       return 31'h3FFF_FFFF + SEED_W'($urandom_range(0, 2));
            default: return SEED_W'($urandom);
        endcase
    endfunction

    function automatic logic [SEED_W-1:0] random_bound_field();
        case ($urandom_range(0, 19))
            0:          return '0;
            1:          return 31'h7FFF_FFFF;
            2, 3:       return SEED_W'(1) << $urandom_range(0, 30);
            4, 5:       return 31'h7FFF_FFFF - SEED_W'($urandom_range(0, 1000));
            6, 7, 8, 9: return SEED_W'($urandom_range(1, 100));
            default:    return SEED_W'($urandom);
        endcase
    endfunction

    initial begin
        stim_row_t directed_rows [0:DIRECTED_ROWS-1];
        stim_row_t row;
        int        sent;
        directed_rows = '{
            // first draw after reset, then seed 16807 squared; full bound returns the seed
            '{CMD_DRAW, 31'd0,          31'd0,          1'b1, '{31'd16807, 31'd0, 1'b1}},
            '{CMD_DRAW, 31'h7FFF_FFFF,  31'h7FFF_FFFF,  1'b1,
              '{31'd282475249, 31'd282475249, 1'b1}},
            // loaded zero and loaded modulus both fall back to one
            '{CMD_LOAD, 31'd0,          31'h7FFF_FFFF,  1'b1, '{31'd1, 31'd0, 1'b0}},
            '{CMD_DRAW, 31'd0,          31'd1,          1'b1, '{31'd16807, 31'd0, 1'b1}},
            '{CMD_LOAD, 31'h7FFF_FFFF,  31'd5,          1'b1, '{31'd1, 31'd0, 1'b0}},
            '{CMD_LOAD, 31'h7FFF_FFFE,  31'd0,          1'b1, '{31'h7FFF_FFFE, 31'd0, 1'b0}},
            '{CMD_DRAW, 31'd0,          31'h7FFF_FFFF,  1'b1,
              '{31'd2147466840, 31'd2147466840, 1'b0}},
            '{CMD_DRAW, 31'd0,          31'd1,          1'b0, '0},
            '{CMD_DRAW, 31'd0,          31'd2,          1'b0, '0},
            '{CMD_LOAD, 31'd1,          31'd12345,      1'b1, '{31'd1, 31'd0, 1'b0}},
            '{CMD_LOAD, 31'h2AAA_AAAA,  31'h5555_5555,  1'b1, '{31'h2AAA_AAAA, 31'd0, 1'b0}},
            '{CMD_DRAW, 31'h5555_5555,  31'h2AAA_AAAA,  1'b0, '0},
            '{CMD_LOAD, 31'h5555_5555,  31'h2AAA_AAAA,  1'b1, '{31'h5555_5555, 31'd0, 1'b0}},
            '{CMD_DRAW, 31'h2AAA_AAAA,  31'h5555_5555,  1'b0, '0},
            // zero bound always scales to zero
            '{CMD_DRAW, 31'd0,          31'd0,          1'b0, '0},
            '{CMD_LOAD, 31'h3FFF_FFFF,  31'd0,          1'b1, '{31'h3FFF_FFFF, 31'd0, 1'b0}},
            '{CMD_DRAW, 31'd0,          31'h4000_0000,  1'b0, '0},
            '{CMD_LOAD, 31'h4000_0000,  31'd0,          1'b1, '{31'h4000_0000, 31'd0, 1'b0}},
            '{CMD_DRAW, 31'd0,          31'h7FFF_FFFE,  1'b0, '0}
        };

        gen_seed        = SEED_W'(1);
        aresetn         <= 1'b0;
        s_tvalid        <= 1'b0;
        s_tuser         <= CMD_DRAW;
        s_tdata         <= '0;
        s_pinned        <= 1'b0;
        s_pinned_result <= '0;
        m_tready        <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (sent = 0; sent < TOTAL_ITEMS; sent++) begin
            idle_mode = sent * 3 / TOTAL_ITEMS;
            if (sent < DIRECTED_ROWS) begin
                row = directed_rows[sent];
            end else begin
                row.cmd    = ($urandom_range(0, 99) < 15) ? CMD_LOAD : CMD_DRAW;
                row.seed   = random_seed_field();
                row.bound  = random_bound_field();
                row.pinned = 1'b0;
                row.result = '0;
            end
            send_request(row);
        end
        s_tvalid <= 1'b0;

        while (expected_draws.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
